>>> rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned ACT_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CFG_W = 5;

  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INS_REAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_REAR = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic cfg_wr;
    logic load;
    logic exec;
    logic read;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

>>> rtl/cdq_ctrl.sv
module cdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  cdq_pkg::stat_t stat_i,
  output cdq_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_q, state_d;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.cfg_wr  = cfg_valid_i && cfg_ready_o;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/cdq_dpath.sv
module cdq_dpath #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cdq_pkg::cmd_t                     cmd_i,
  output cdq_pkg::stat_t                    stat_o,
  input  logic [cdq_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [cdq_pkg::ACT_W-1:0]         action_i,
  input  logic signed [cdq_pkg::KEY_W-1:0]  key_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cdq_pkg::STAT_W-1:0]        status_o,
  output logic signed [cdq_pkg::KEY_W-1:0]  front_value_o,
  output logic signed [cdq_pkg::KEY_W-1:0]  rear_value_o,
  output logic                              has_items_o,
  output logic                              is_full_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CAP_W = $clog2(DEPTH + 1);
  localparam int unsigned CAP_RST = (DEPTH < 16) ? DEPTH : 16;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [cdq_pkg::ACT_W-1:0]  act_q;
  logic [DATA_WIDTH-1:0]      key_q;
  logic [IDX_W-1:0]           front_q, front_d, rear_q, rear_d, waddr;
  logic                       empty_q, empty_d, we;
  logic [CAP_W-1:0]           cap_q, cap_d;
  logic [cdq_pkg::STAT_W-1:0] res_q, res_d;
  logic [DATA_WIDTH-1:0]      rd_front_q, rd_rear_q;
  logic [63:0]                key_ext, rdf_ext, rdr_ext;
  logic                       full, is_ins;
  logic                       out_valid_q;
  logic [cdq_pkg::STAT_W-1:0] status_q;
  logic [cdq_pkg::KEY_W-1:0]  front_val_q, rear_val_q;
  logic                       has_q, full_q;
  logic [cdq_pkg::CFG_W-1:0]  cfg_v;

  function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i,
                                               input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] nxt;
    nxt = (CAP_W+1)'(i) + 1'b1;
    return (nxt >= (CAP_W+1)'(cap)) ? '0 : nxt[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] top;
    top = cap - 1'b1;
    return (i == '0) ? top[IDX_W-1:0] : i - 1'b1;
  endfunction

  assign key_ext = {32'b0, key_value_i};
  assign full    = !empty_q && (wrap_up(rear_q, cap_q) == front_q);
  assign is_ins  = (act_q == cdq_pkg::ACT_INS_FRONT) || (act_q == cdq_pkg::ACT_INS_REAR);
  assign cfg_v   = (cfg_data_i == '0) ? cdq_pkg::CFG_W'(1) : cfg_data_i;

  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    empty_d = empty_q;
    cap_d   = cap_q;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = '0;
    if (cmd_i.cfg_wr) begin
      cap_d   = (32'(cfg_v) > DEPTH) ? CAP_W'(DEPTH) : CAP_W'(cfg_v);
      front_d = '0;
      rear_d  = '0;
      empty_d = 1'b1;
    end else if (cmd_i.exec) begin
      res_d = cdq_pkg::ST_OK;
      if (is_ins) begin
        if (full) begin
          res_d = cdq_pkg::ST_OVERFLOW;
        end else if (empty_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b0;
          we      = 1'b1;
        end else if (act_q == cdq_pkg::ACT_INS_FRONT) begin
          front_d = wrap_down(front_q, cap_q);
          waddr   = front_d;
          we      = 1'b1;
        end else begin
          rear_d = wrap_up(rear_q, cap_q);
          waddr  = rear_d;
          we     = 1'b1;
        end
      end else begin
        if (empty_q) begin
          res_d = cdq_pkg::ST_UNDERFLOW;
        end else if (front_q == rear_q) begin
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b1;
        end else if (act_q == cdq_pkg::ACT_DEL_FRONT) begin
          front_d = wrap_up(front_q, cap_q);
        end else begin
          rear_d = wrap_down(rear_q, cap_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= key_q;
    end
    if (cmd_i.read) begin
      rd_front_q <= mem[front_q];
      rd_rear_q  <= mem[rear_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      key_q <= key_ext[DATA_WIDTH-1:0];
    end
    res_q <= res_d;
  end

  assign rdf_ext = 64'(rd_front_q);
  assign rdr_ext = 64'(rd_rear_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      status_q    <= res_q;
      front_val_q <= empty_q ? '0 : rdf_ext[cdq_pkg::KEY_W-1:0];
      rear_val_q  <= empty_q ? '0 : rdr_ext[cdq_pkg::KEY_W-1:0];
      has_q       <= !empty_q;
      full_q      <= full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      rear_q      <= '0;
      empty_q     <= 1'b1;
      cap_q       <= CAP_W'(CAP_RST);
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
      cap_q   <= cap_d;
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign front_value_o   = $signed(front_val_q);
  assign rear_value_o    = $signed(rear_val_q);
  assign has_items_o     = has_q;
  assign is_full_o       = full_q;

endmodule

>>> rtl/circular_double_ended_queue_unit.sv
// An accepted request is loaded, then exec, slot read and response run in turn through
// the single-write, dual-read slot memory; the response step waits for a free output
// register. The next request is taken only after the last one has responded.
// A waiting result does not block the next request until that request's response step.
// Reset: deque empty, both indices 0, capacity min(16, DEPTH); slot contents not cleared.
module circular_double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cdq_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cdq_pkg::ACT_W-1:0]         action_i,
  input  logic signed [cdq_pkg::KEY_W-1:0]  key_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cdq_pkg::STAT_W-1:0]        status_o,
  output logic signed [cdq_pkg::KEY_W-1:0]  front_value_o,
  output logic signed [cdq_pkg::KEY_W-1:0]  rear_value_o,
  output logic                              has_items_o,
  output logic                              is_full_o
);

  cdq_pkg::cmd_t  cmd;
  cdq_pkg::stat_t stat;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cdq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_data_i    (cfg_data_i),
    .action_i      (action_i),
    .key_value_i   (key_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .has_items_o   (has_items_o),
    .is_full_o     (is_full_o)
  );

  a_full_has_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_full_o |-> has_items_o)
    else $error("full result without items");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_items_o |-> front_value_o == '0 && rear_value_o == '0)
    else $error("empty result carries nonzero values");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == cdq_pkg::ST_UNDERFLOW |-> !has_items_o)
    else $error("underflow on nonempty deque");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == cdq_pkg::ST_OVERFLOW |-> is_full_o)
    else $error("overflow on deque that is not full");

endmodule
